/* src/ffa_pkg.sv */
`default_nettype none
package ffa_pkg;

  localparam int MEM_UNITS = 1024;
  localparam int LEN_W     = 11;
  localparam int AW        = $clog2(MEM_UNITS);
  localparam int OW        = ((AW > LEN_W) ? AW : LEN_W) + 1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic             free;
    logic [LEN_W-1:0] len;
  } ffa_entry_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WALK, S_EVAL, S_SPLIT, S_MARK,
    S_FNEXT, S_FNEVAL, S_FWRITE, S_DONE
  } ffa_state_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_INIT, WR_SPLIT, WR_MARK, WR_FREE
  } ffa_wr_t;

  typedef enum logic [2:0] {
    RES_NONE, RES_GRANT, RES_OK, RES_NO_SPACE, RES_NOT_FOUND
  } ffa_res_t;

  typedef struct packed {
    logic    load;
    logic    adv;
    logic    save_len;
    logic    add_tlen;
    logic    rd_nxt;
    ffa_wr_t wr;
    ffa_res_t res;
  } ffa_cmd_t;

  typedef struct packed {
    logic in_act;
    logic action;
    logic size_zero;
    logic tgt_oor;
    logic off_lt_r;
    logic fit;
    logic exact;
    logic at_target;
    logic nxt_lt_r;
    logic rd_free;
  } ffa_stat_t;

endpackage
`default_nettype wire

/* src/first_fit_allocator_unit.sv */
// First-fit allocator with coalescing over a byte region of up to 1024 bytes. A request is
// taken when start is high, busy is low and no configuration write comes in that cycle, and
// its single result appears on out_status and out_granted_address for one cycle with
// out_valid high; the receiver cannot stall, so it must take the result in that cycle. A
// request walks the block chain in address order, visiting each block through the walk and
// evaluate states and the registered read of the block store. A zero size or an out-of-range
// free address skips the walk and goes straight to the done state. After reset and after a
// configuration write taken while idle, the block is busy in its init state while it sets
// the region up as one free block.
`default_nettype none
module first_fit_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [10:0] in_request_size,
  input  wire logic [31:0] in_block_address,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_granted_address,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ffa_pkg::*;

  logic [31:0]      base_r;
  logic [LEN_W-1:0] units_r;
  logic             cfg_wr;
  ffa_cmd_t         cmd;
  ffa_stat_t        stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      units_r <= LEN_W'(1024);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        units_r <= pwdata[LEN_W-1:0];
      end else begin
        base_r <= pwdata;
      end
    end
  end

  assign prdata = paddr[2] ? 32'(units_r) : base_r;

  ffa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cfg_wr (cfg_wr),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (out_valid)
  );

  ffa_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .base_address     (base_r),
    .region_units     (units_r),
    .in_action        (in_action),
    .in_request_size  (in_request_size),
    .in_block_address (in_block_address),
    .stat             (stat),
    .status           (out_status),
    .granted_address  (out_granted_address)
  );

endmodule
`default_nettype wire

/* src/ffa_ram.sv */
`default_nettype none
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/ffa_ctrl.sv */
`default_nettype none
module ffa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               cfg_wr,
  input  wire ffa_pkg::ffa_stat_t stat,
  output ffa_pkg::ffa_cmd_t       cmd,
  output logic                    busy,
  output logic                    done
);
  import ffa_pkg::*;

  ffa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (cfg_wr) begin
          state_nxt = S_INIT;
        end else if (start) begin
          if (stat.in_act == ACT_ALLOC) begin
            state_nxt = stat.size_zero ? S_DONE : S_WALK;
          end else begin
            state_nxt = stat.tgt_oor ? S_DONE : S_WALK;
          end
        end
      end
      S_WALK: state_nxt = stat.off_lt_r ? S_EVAL : S_DONE;
      S_EVAL: begin
        if (stat.action == ACT_ALLOC) begin
          if (stat.fit) begin
            state_nxt = stat.exact ? S_MARK : S_SPLIT;
          end else begin
            state_nxt = S_WALK;
          end
        end else begin
          state_nxt = stat.at_target ? S_FNEXT : S_WALK;
        end
      end
      S_SPLIT:  state_nxt = S_MARK;
      S_MARK:   state_nxt = S_DONE;
      S_FNEXT:  state_nxt = stat.nxt_lt_r ? S_FNEVAL : S_FWRITE;
      S_FNEVAL: state_nxt = S_FWRITE;
      S_FWRITE: state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd  = '{load: 1'b0, adv: 1'b0, save_len: 1'b0, add_tlen: 1'b0, rd_nxt: 1'b0,
             wr: WR_NONE, res: RES_NONE};
    busy = 1'b1;
    done = 1'b0;
    case (state_r)
      S_INIT: cmd.wr = WR_INIT;
      S_IDLE: begin
        busy = 1'b0;
        if (start && !cfg_wr) begin
          cmd.load = 1'b1;
          if (stat.in_act == ACT_ALLOC && stat.size_zero) begin
            cmd.res = RES_NO_SPACE;
          end else if (stat.in_act == ACT_FREE && stat.tgt_oor) begin
            cmd.res = RES_NOT_FOUND;
          end
        end
      end
      S_WALK: begin
        if (!stat.off_lt_r) begin
          cmd.res = (stat.action == ACT_ALLOC) ? RES_NO_SPACE : RES_NOT_FOUND;
        end
      end
      S_EVAL: begin
        if (stat.action == ACT_ALLOC) begin
          cmd.save_len = stat.fit;
          cmd.adv      = !stat.fit;
        end else begin
          cmd.save_len = stat.at_target;
          cmd.adv      = !stat.at_target;
        end
      end
      S_SPLIT:  cmd.wr = WR_SPLIT;
      S_MARK: begin
        cmd.wr  = WR_MARK;
        cmd.res = RES_GRANT;
      end
      S_FNEXT:  cmd.rd_nxt = 1'b1;
      S_FNEVAL: cmd.add_tlen = stat.rd_free;
      S_FWRITE: begin
        cmd.wr  = WR_FREE;
        cmd.res = RES_OK;
      end
      S_DONE:   done = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

/* src/ffa_dp.sv */
`default_nettype none
module ffa_dp (
  input  wire logic                      clk,
  input  wire ffa_pkg::ffa_cmd_t         cmd,
  input  wire logic [31:0]               base_address,
  input  wire logic [ffa_pkg::LEN_W-1:0] region_units,
  input  wire logic                      in_action,
  input  wire logic [10:0]               in_request_size,
  input  wire logic [31:0]               in_block_address,
  output ffa_pkg::ffa_stat_t             stat,
  output logic [1:0]                     status,
  output logic [31:0]                    granted_address
);
  import ffa_pkg::*;

  localparam logic [OW-1:0] MEM_UNITS_W = OW'(MEM_UNITS);

  logic             action_r;
  logic [LEN_W-1:0] size_r;
  logic [OW-1:0]    off_r, target_r, run_s_r;
  logic             run_v_r;
  logic [LEN_W-1:0] len_r, tlen_r;
  logic [1:0]       status_r;
  logic [31:0]      granted_r;

  logic [OW-1:0]    rsize, nxt, fstart, waddr_w, raddr_w;
  logic [31:0]      tdiff;
  ffa_entry_t       rd, wdata;
  logic             wr_en;
  logic [LEN_W-1:0] lenx;

  assign rsize = (OW'(region_units) > MEM_UNITS_W) ? MEM_UNITS_W : OW'(region_units);
  assign tdiff = in_block_address - base_address;
  assign nxt   = target_r + OW'(tlen_r);
  assign lenx  = (rd.len == '0) ? LEN_W'(1) : rd.len;
  assign fstart = run_v_r ? run_s_r : target_r;

  always_comb begin
    stat.in_act    = in_action;
    stat.action    = action_r;
    stat.size_zero = (in_request_size == '0);
    stat.tgt_oor   = (tdiff >= 32'(rsize));
    stat.off_lt_r  = (off_r < rsize);
    stat.fit       = rd.free && (rd.len >= size_r);
    stat.exact     = (rd.len == size_r);
    stat.at_target = (off_r == target_r);
    stat.nxt_lt_r  = (nxt < rsize);
    stat.rd_free   = rd.free;
  end

  always_comb begin
    wr_en   = 1'b1;
    waddr_w = '0;
    wdata   = '{free: 1'b1, len: rsize[LEN_W-1:0]};
    case (cmd.wr)
      WR_INIT: begin
        waddr_w = '0;
        wdata   = '{free: 1'b1, len: rsize[LEN_W-1:0]};
      end
      WR_SPLIT: begin
        waddr_w = off_r + OW'(size_r);
        wdata   = '{free: 1'b1, len: len_r - size_r};
      end
      WR_MARK: begin
        waddr_w = off_r;
        wdata   = '{free: 1'b0, len: size_r};
      end
      WR_FREE: begin
        waddr_w = fstart;
        wdata   = '{free: 1'b1, len: LEN_W'(nxt - fstart)};
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign raddr_w = cmd.rd_nxt ? nxt : off_r;

  ffa_ram #(.WIDTH($bits(ffa_entry_t)), .DEPTH(MEM_UNITS)) u_ram (
    .clk   (clk),
    .wr_en (wr_en),
    .waddr (waddr_w[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_w[AW-1:0]),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      size_r   <= in_request_size;
      target_r <= tdiff[OW-1:0];
      off_r    <= '0;
      run_v_r  <= 1'b0;
    end
    if (cmd.adv) begin
      off_r <= off_r + OW'(lenx);
      if (rd.free) begin
        if (!run_v_r) begin
          run_s_r <= off_r;
          run_v_r <= 1'b1;
        end
      end else begin
        run_v_r <= 1'b0;
      end
    end
    if (cmd.save_len) begin
      len_r  <= rd.len;
      tlen_r <= rd.len;
    end
    if (cmd.add_tlen) begin
      tlen_r <= tlen_r + rd.len;
    end
    case (cmd.res)
      RES_GRANT: begin
        status_r  <= ST_OK;
        granted_r <= base_address + 32'(off_r);
      end
      RES_OK: begin
        status_r  <= ST_OK;
        granted_r <= '0;
      end
      RES_NO_SPACE: begin
        status_r  <= ST_NO_SPACE;
        granted_r <= '0;
      end
      RES_NOT_FOUND: begin
        status_r  <= ST_NOT_FOUND;
        granted_r <= '0;
      end
      default: begin
      end
    endcase
  end

  assign status          = status_r;
  assign granted_address = granted_r;

endmodule
`default_nettype wire

/* src/ffa_checker.sv */
`default_nettype none
module ffa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_granted_address
);
  import ffa_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid) else $error("not idle after result");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  a_zero_addr_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_granted_address == 32'd0)
    else $error("address on failed request");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NOT_FOUND) else $error("bad status code");

endmodule

bind first_fit_allocator_unit ffa_checker u_ffa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_status          (out_status),
  .out_granted_address (out_granted_address)
);
`default_nettype wire

/* tb/sv/first_fit_allocator_unit_tb.sv */
`timescale 1ns / 100ps
module first_fit_allocator_unit_tb;
  import ffa_pkg::*;

  class alloc_scoreboard;
    logic [31:0] base_addr;
    logic [10:0] units;
    bit          starts [MEM_UNITS];
    bit          frees [MEM_UNITS];
    int          lens [MEM_UNITS];
    logic [1:0]  want_status [$];
    logic [31:0] want_addr [$];
    logic [31:0] live_blocks [$];
    int          errors;

    function int span();
      return (units > MEM_UNITS) ? MEM_UNITS : units;
    endfunction

    function void rebuild();
      foreach (starts[i]) begin
        starts[i] = 0;
        frees[i] = 0;
        lens[i] = 0;
      end
      live_blocks.delete();
      if (span() > 0) begin
        starts[0] = 1;
        frees[0] = 1;
        lens[0] = span();
      end
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      if (idx == 0) base_addr = value;
      else units = value[10:0];
      rebuild();
    endfunction

    function int step_off(int off);
      return off + ((lens[off] == 0) ? 1 : lens[off]);
    endfunction

    function logic [1:0] allocate(int size, output logic [31:0] addr);
      int off;
      off = 0;
      addr = '0;
      if (size == 0) return ST_NO_SPACE;
      while (off < span()) begin
        if (starts[off] && frees[off] && lens[off] >= size) begin
          if (lens[off] > size) begin
            starts[off + size] = 1;
            frees[off + size] = 1;
            lens[off + size] = lens[off] - size;
            lens[off] = size;
          end
          frees[off] = 0;
          addr = base_addr + off;
          return ST_OK;
        end
        off = step_off(off);
      end
      return ST_NO_SPACE;
    endfunction

    function logic [1:0] release_block(logic [31:0] addr);
      logic [31:0] rel;
      int tgt, off, prv, nxt, p, q;
      bit has_prv, hp;
      rel = addr - base_addr;
      if (rel >= span()) return ST_NOT_FOUND;
      tgt = rel;
      if (!starts[tgt]) return ST_NOT_FOUND;
      off = 0;
      has_prv = 0;
      prv = 0;
      while (off < span() && off != tgt) begin
        has_prv = 1;
        prv = off;
        off = step_off(off);
      end
      if (off != tgt) return ST_NOT_FOUND;
      frees[tgt] = 1;
      nxt = step_off(tgt);
      if (nxt < span() && starts[nxt] && frees[nxt]) begin
        lens[tgt] += lens[nxt];
        starts[nxt] = 0;
        frees[nxt] = 0;
      end
      while (has_prv && frees[prv]) begin
        lens[prv] += lens[tgt];
        starts[tgt] = 0;
        frees[tgt] = 0;
        tgt = prv;
        p = 0;
        hp = 0;
        q = 0;
        while (p < span() && p != tgt) begin
          hp = 1;
          q = p;
          p = step_off(p);
        end
        has_prv = hp;
        prv = q;
      end
      return ST_OK;
    endfunction

    function void note_item(logic act, logic [10:0] size, logic [31:0] addr);
      logic [1:0]  st;
      logic [31:0] ga;
      ga = '0;
      if (act == ACT_ALLOC) begin
        st = allocate(size, ga);
        if (st == ST_OK) live_blocks.push_back(ga);
      end else begin
        st = release_block(addr);
        foreach (live_blocks[i])
          if (st == ST_OK && live_blocks[i] == addr) begin
            live_blocks.delete(i);
            break;
          end
      end
      if (st != ST_OK || act != ACT_ALLOC) ga = '0;
      want_status.push_back(st);
      want_addr.push_back(ga);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] ga);
      logic [1:0]  es;
      logic [31:0] ea;
      if (want_status.size() == 0) begin
        $error("unexpected result: status %0d granted_address %h", st, ga);
        errors++;
        return;
      end
      es = want_status.pop_front();
      ea = want_addr.pop_front();
      if (st !== es) begin
        $error("status: expected %0d, actual %0d", es, st);
        errors++;
      end
      if (ga !== ea) begin
        $error("granted_address: expected %h, actual %h", ea, ga);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [10:0] in_request_size;
  logic [31:0] in_block_address;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_granted_address;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  alloc_scoreboard sb;
  bit              idle_on;

  first_fit_allocator_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_request_size(in_request_size),
    .in_block_address(in_block_address), .out_valid(out_valid),
    .out_status(out_status), .out_granted_address(out_granted_address),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_item(in_action, in_request_size, in_block_address);
      if (psel && penable && pwrite && pready) sb.write_reg(paddr >> 2, pwdata);
      if (out_valid) sb.check_result(out_status, out_granted_address);
    end
  end

  task automatic send_item(logic act, logic [10:0] size, logic [31:0] addr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_request_size <= size;
    in_block_address <= addr;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.want_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_items(int count);
    int          cap, pick;
    logic [10:0] size;
    logic [31:0] addr;
    cap = sb.span();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        size = (cap < 2) ? 11'd1 : 11'($urandom_range(1, (cap + 3) / 4));
        send_item(ACT_ALLOC, size, $urandom);
      end else if (pick < 58) begin
        send_item(ACT_ALLOC, 11'($urandom), $urandom);
      end else if (pick < 85 && sb.live_blocks.size() != 0) begin
        addr = sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)];
        send_item(ACT_FREE, 11'($urandom), addr);
      end else if (pick < 93) begin
        addr = sb.base_addr + $urandom_range(0, cap);
        send_item(ACT_FREE, 11'($urandom), addr);
      end else begin
        send_item(ACT_FREE, 11'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    int          sizes [12];
    logic [31:0] bases [12];
    sb = new();
    sb.base_addr = '0;
    sb.units = 11'd1024;
    sb.rebuild();
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_ALLOC;
    in_request_size = '0;
    in_block_address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(ACT_ALLOC, 11'd0, 32'd0);
    send_item(ACT_ALLOC, 11'd2047, 32'hFFFF_FFFF);
    send_item(ACT_ALLOC, 11'd1024, 32'd0);
    send_item(ACT_ALLOC, 11'd1, 32'd0);
    send_item(ACT_FREE, 11'd0, 32'd5);
    send_item(ACT_FREE, 11'd2047, 32'd0);
    send_item(ACT_FREE, 11'd0, 32'd0);
    send_item(ACT_FREE, 11'd0, 32'hFFFF_FFFF);
    send_item(ACT_ALLOC, 11'd1023, 32'd0);
    send_item(ACT_ALLOC, 11'd1, 32'd0);
    send_item(ACT_FREE, 11'd0, 32'd0);
    send_item(ACT_FREE, 11'd0, 32'd1023);
    write_reg(1, 32'd0);
    send_item(ACT_ALLOC, 11'd1, 32'd0);
    send_item(ACT_FREE, 11'd0, 32'd0);
    write_reg(0, 32'hFFFF_FFF8);
    write_reg(1, 32'd2047);
    send_item(ACT_ALLOC, 11'd16, 32'd0);
    send_item(ACT_ALLOC, 11'd1, 32'd0);
    send_item(ACT_FREE, 11'd0, 32'h0000_0008);
    write_reg(1, 32'd8);
    send_item(ACT_ALLOC, 11'd8, 32'd0);
    send_item(ACT_ALLOC, 11'd1, 32'd0);
    send_item(ACT_FREE, 11'd0, 32'hFFFF_FFF8);

    sizes = '{1, 16, 40, 1024, 24, 2047, 64, 9, 32, 1024, 48, 20};
    bases = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'h0, $urandom, 32'hFFFF_FF00,
              $urandom, $urandom, 32'h8000_0000, $urandom, $urandom, $urandom};
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(0, bases[ph]);
      write_reg(1, sizes[ph]);
      if (ph >= 10) idle_on = 1'b0;
      random_items((sizes[ph] >= 1024) ? 30 : 50);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("first_fit_allocator_unit_tb: done, clean");
    end else begin
      $display("first_fit_allocator_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("first_fit_allocator_unit_tb: done, errors");
    $finish;
  end

endmodule
